### hdl/stc_pkg.sv
// Shared types and constants for the sensor temperature frame checker.
package stc_pkg;

	// Frame byte positions
	localparam logic [2:0] POS_AMB_HI  = 3'd0;
	localparam logic [2:0] POS_AMB_LO  = 3'd1;
	localparam logic [2:0] POS_AMB_CRC = 3'd2;
	localparam logic [2:0] POS_OBJ_HI  = 3'd3;
	localparam logic [2:0] POS_OBJ_LO  = 3'd4;
	localparam logic [2:0] POS_OBJ_CRC = 3'd5;

	// CRC-8 constants: polynomial 0x31, seed 0xFF, MSB first
	localparam logic [7:0] CRC_POLY = 8'h31;
	localparam logic [7:0] CRC_INIT = 8'hFF;

	// One end-of-frame result
	typedef struct packed {
		logic signed [15:0] ambient_tenths;
		logic signed [15:0] object_tenths;
		logic               ambient_fresh;
		logic               object_fresh;
	} result_t;

endpackage

### hdl/stc_in_stage.sv
// Input register stage holding one received byte transaction.
module stc_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       frame_start,
	input  logic       adv,
	output logic       valid_s1,
	output logic [7:0] rx_byte_s1,
	output logic       frame_start_s1
);

	// Accept when empty or when the held byte moves on this cycle
	assign in_ready = !valid_s1 || adv;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Capture payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1     <= rx_byte;
			frame_start_s1 <= frame_start;
		end
	end

endmodule

### hdl/stc_frame_core.sv
// Frame position tracking, running CRC-8 and temperature stores.
module stc_frame_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic [7:0]      rx_byte_s1,
	input  logic            frame_start_s1,
	output logic            emit,
	output stc_pkg::result_t result
);
	import stc_pkg::*;

	logic [2:0]  pos_q;
	logic [7:0]  crc_q;
	logic [7:0]  hi_q;
	logic [7:0]  lo_q;
	logic [15:0] amb_q;
	logic [15:0] obj_q;
	logic        amb_ok_q;

	logic [2:0]  pos_eff;
	logic        restart;
	logic [15:0] word;
	logic        match;

	// Unrolled MSB-first CRC-8 byte step
	function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] c;
		c = crc ^ data;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

	// Resolve effective position and word check
	assign restart = frame_start_s1 || (pos_q > POS_OBJ_CRC);
	assign pos_eff = restart ? POS_AMB_HI : pos_q;
	assign word    = {hi_q, lo_q};
	assign match   = (crc_q == rx_byte_s1);
	assign emit    = (pos_eff == POS_OBJ_CRC);

	// Form the end-of-frame result
	always_comb begin
		result.ambient_tenths = amb_q;
		result.object_tenths  = match ? word : obj_q;
		result.ambient_fresh  = amb_ok_q;
		result.object_fresh   = match;
	end

	// Advance frame state on each processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_AMB_HI;
			crc_q    <= CRC_INIT;
			hi_q     <= '0;
			lo_q     <= '0;
			amb_q    <= '0;
			obj_q    <= '0;
			amb_ok_q <= 1'b0;
		end else if (adv) begin
			unique case (pos_eff) inside
				POS_AMB_HI, POS_OBJ_HI: begin
					hi_q     <= rx_byte_s1;
					crc_q    <= crc_step(CRC_INIT, rx_byte_s1);
					pos_q    <= pos_eff + 3'd1;
					amb_ok_q <= restart ? 1'b0 : amb_ok_q;
				end
				POS_AMB_LO, POS_OBJ_LO: begin
					lo_q  <= rx_byte_s1;
					crc_q <= crc_step(crc_q, rx_byte_s1);
					pos_q <= pos_eff + 3'd1;
				end
				POS_AMB_CRC: begin
					if (match) begin
						amb_q <= word;
					end
					amb_ok_q <= match;
					crc_q    <= CRC_INIT;
					pos_q    <= POS_OBJ_HI;
				end
				default: begin
					if (match) begin
						obj_q <= word;
					end
					crc_q    <= CRC_INIT;
					amb_ok_q <= 1'b0;
					pos_q    <= POS_AMB_HI;
				end
			endcase
		end
	end

endmodule

### hdl/stc_out_stage.sv
// Result register that holds one result transaction until it is taken.
module stc_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  stc_pkg::result_t result,
	output logic             free,
	output logic             out_valid,
	input  logic             out_ready,
	output logic signed [15:0] ambient_tenths,
	output logic signed [15:0] object_tenths,
	output logic             ambient_fresh,
	output logic             object_fresh
);
	import stc_pkg::*;

	// Slot can take a new result when empty or draining this cycle
	assign free = !out_valid || out_ready;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Capture result payload
	always_ff @(posedge clk) begin
		if (load) begin
			ambient_tenths <= result.ambient_tenths;
			object_tenths  <= result.object_tenths;
			ambient_fresh  <= result.ambient_fresh;
			object_fresh   <= result.object_fresh;
		end
	end

endmodule

### hdl/sensor_temperature_frame_checker.sv
// Top level of the sensor temperature frame checker.
//
// Input channel (in_valid/in_ready, rx_byte, frame_start) carries one frame
// byte per transaction: ambient high, low, CRC, then object high, low, CRC.
// frame_start marks byte 0 and abandons any partial frame.
// Output channel (out_valid/out_ready) carries one transaction per frame,
// after the sixth byte: both stored temperatures in raw tenths and two flags
// telling which CRC-8 (poly 0x31, seed 0xFF) checks passed in this frame.
// Throughput: one byte per cycle while the result slot can take each result,
// set by the combinational CRC byte step after the input register.
// Path: the last byte is held in the input register, then its result is
// loaded into the result register, where it is valid.
// Reset returns the frame position to byte 0, the CRC to its seed and both
// stored temperatures to zero; no result is pending after reset.
// If the receiver stalls, the result register holds; bytes that make no
// result keep flowing, and a sixth byte waits in the input register, holding
// in_ready low, until the result slot frees.
module sensor_temperature_frame_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        rx_byte,
	input  logic              frame_start,
	output logic              out_valid,
	input  logic              out_ready,
	output logic signed [15:0] ambient_tenths,
	output logic signed [15:0] object_tenths,
	output logic              ambient_fresh,
	output logic              object_fresh
);
	import stc_pkg::*;

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       frame_start_s1;
	logic       adv;
	logic       emit;
	logic       free;
	result_t    result;

	// Move the held byte unless its result has nowhere to go
	assign adv = valid_s1 && (!emit || free);

	stc_in_stage u_in (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.frame_start    (frame_start),
		.adv            (adv),
		.valid_s1       (valid_s1),
		.rx_byte_s1     (rx_byte_s1),
		.frame_start_s1 (frame_start_s1)
	);

	stc_frame_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.adv            (adv),
		.rx_byte_s1     (rx_byte_s1),
		.frame_start_s1 (frame_start_s1),
		.emit           (emit),
		.result         (result)
	);

	stc_out_stage u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (adv && emit),
		.result         (result),
		.free           (free),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.ambient_tenths (ambient_tenths),
		.object_tenths  (object_tenths),
		.ambient_fresh  (ambient_fresh),
		.object_fresh   (object_fresh)
	);

endmodule
